[rtl/core/wbc_pkg.sv]
// ---------------------------------------------------------------------------
// wbc_pkg
// Shared types, register indexes and helpers for the window blend compositor.
// ---------------------------------------------------------------------------
package wbc_pkg;

  localparam int unsigned CoefMax = 16;

  typedef enum logic [2:0] {
    REG_WIN0_RECT    = 3'd0,
    REG_WIN1_RECT    = 3'd1,
    REG_WINDOW_MASKS = 3'd2,
    REG_BLEND_MODE   = 3'd3,
    REG_COEF_A       = 3'd4,
    REG_COEF_B       = 3'd5,
    REG_COEF_Y       = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    BLEND_NONE     = 2'd0,
    BLEND_ALPHA    = 2'd1,
    BLEND_BRIGHTEN = 2'd2,
    BLEND_DARKEN   = 2'd3
  } blend_mode_t;

  typedef struct packed {
    logic visible;
    logic fx;
  } win_res_t;

  function automatic logic [4:0] clamp16(input logic [4:0] v);
    clamp16 = (v > 5'(CoefMax)) ? 5'(CoefMax) : v;
  endfunction

endpackage

[rtl/core/wbc_window.sv]
// ---------------------------------------------------------------------------
// wbc_window
// Resolves the window mask for one pixel and the layer's write and effect bits.
// ---------------------------------------------------------------------------
module wbc_window import wbc_pkg::*; (
  input  logic [7:0]  pix_x,
  input  logic [7:0]  pix_y,
  input  logic [2:0]  layer,
  input  logic [31:0] win0_rect,
  input  logic [31:0] win1_rect,
  input  logic [23:0] window_masks,
  output win_res_t    res
);

  function automatic logic axis_in(input logic [7:0] lo, input logic [7:0] hi,
                                   input logic [7:0] c);
    if (lo <= hi) begin
      axis_in = (c >= lo) && (c < hi);
    end else begin
      axis_in = (c >= lo) || (c < hi);
    end
  endfunction

  logic       in_w0;
  logic       in_w1;
  logic [7:0] mask;

  assign in_w0 = axis_in(win0_rect[7:0], win0_rect[15:8], pix_x) &&
                 axis_in(win0_rect[23:16], win0_rect[31:24], pix_y);
  assign in_w1 = axis_in(win1_rect[7:0], win1_rect[15:8], pix_x) &&
                 axis_in(win1_rect[23:16], win1_rect[31:24], pix_y);

  always_comb begin
    if (in_w0) begin
      mask = window_masks[7:0];
    end else if (in_w1) begin
      mask = window_masks[15:8];
    end else begin
      mask = window_masks[23:16];
    end
    res.visible = (layer <= 3'd4) && mask[layer];
    res.fx      = mask[5];
  end

endmodule

[rtl/core/wbc_blend.sv]
// ---------------------------------------------------------------------------
// wbc_blend
// Per-channel color effect: pass, weighted blend, brighten or darken.
// ---------------------------------------------------------------------------
module wbc_blend import wbc_pkg::*; (
  input  blend_mode_t mode,
  input  logic [4:0]  coef_a,
  input  logic [4:0]  coef_b,
  input  logic [4:0]  coef_y,
  input  logic        fx,
  input  logic [31:0] src_rgba,
  input  logic [31:0] dst_color,
  output logic [31:0] color
);

  logic [4:0] ca;
  logic [4:0] cb;
  logic [4:0] cy;

  assign ca = clamp16(coef_a);
  assign cb = clamp16(coef_b);
  assign cy = clamp16(coef_y);

  always_comb begin
    logic [7:0]  s;
    logic [7:0]  d;
    logic [13:0] sum;
    logic [12:0] prod;
    logic [8:0]  v;
    color = 32'hFF;
    for (int i = 1; i < 4; i++) begin
      s    = src_rgba[i*8 +: 8];
      d    = dst_color[i*8 +: 8];
      sum  = '0;
      prod = '0;
      case (mode)
        BLEND_ALPHA: begin
          sum = 14'(s) * 14'(ca) + 14'(d) * 14'(cb);
          v   = sum[12:4];
        end
        BLEND_BRIGHTEN: begin
          prod = (13'(8'hFF) - 13'(s)) * 13'(cy);
          v    = 9'(s) + 9'(prod[12:4]);
        end
        BLEND_DARKEN: begin
          prod = 13'(s) * (13'(CoefMax) - 13'(cy));
          v    = 9'(prod[12:4]);
        end
        default: begin
          v = 9'(s);
        end
      endcase
      color[i*8 +: 8] = v[8] ? 8'hFF : v[7:0];
    end
    if (!fx || mode == BLEND_NONE) begin
      color = src_rgba;
    end
  end

endmodule

[rtl/core/window_blend_compositor.sv]
// ---------------------------------------------------------------------------
// window_blend_compositor
// Per-pixel window mask resolve and color blend, one pixel per clock.
// ---------------------------------------------------------------------------
// channel  handshake              word
// in       start / busy           pix_x, pix_y, layer, src_rgba, dst_color
// out      out_valid strobe       write_enable, out_color
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel per cycle; busy stays low. The result passes through the input
// register, then the result register.
// Reset is synchronous; config registers take their reset values.
// out_valid is a one-cycle strobe; the receiver cannot stall.
// ---------------------------------------------------------------------------
module window_blend_compositor import wbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_pix_x,
  input  logic [7:0]  in_pix_y,
  input  logic [2:0]  in_layer,
  input  logic [31:0] in_src_rgba,
  input  logic [31:0] in_dst_color,
  output logic        out_valid,
  output logic        out_write_enable,
  output logic [31:0] out_color,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] win0_rect_r;
  logic [31:0] win1_rect_r;
  logic [23:0] window_masks_r;
  blend_mode_t blend_mode_r;
  logic [4:0]  coef_a_r;
  logic [4:0]  coef_b_r;
  logic [4:0]  coef_y_r;

  logic        in_vld_r;
  logic [7:0]  pix_x_r;
  logic [7:0]  pix_y_r;
  logic [2:0]  layer_r;
  logic [31:0] src_r;
  logic [31:0] dst_r;

  logic        out_vld_r;
  logic        we_r;
  logic        we_nxt;
  logic [31:0] color_r;
  logic [31:0] color_nxt;

  win_res_t    wres;
  logic [31:0] fx_color;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win0_rect_r    <= '0;
      win1_rect_r    <= '0;
      window_masks_r <= 24'h3F0000;
      blend_mode_r   <= BLEND_NONE;
      coef_a_r       <= '0;
      coef_b_r       <= '0;
      coef_y_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_WIN0_RECT:    win0_rect_r    <= cfg_data;
        REG_WIN1_RECT:    win1_rect_r    <= cfg_data;
        REG_WINDOW_MASKS: window_masks_r <= cfg_data[23:0];
        REG_BLEND_MODE:   blend_mode_r   <= blend_mode_t'(cfg_data[1:0]);
        REG_COEF_A:       coef_a_r       <= cfg_data[4:0];
        REG_COEF_B:       coef_b_r       <= cfg_data[4:0];
        REG_COEF_Y:       coef_y_r       <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start && !busy;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      pix_x_r <= in_pix_x;
      pix_y_r <= in_pix_y;
      layer_r <= in_layer;
      src_r   <= in_src_rgba;
      dst_r   <= in_dst_color;
    end
    if (in_vld_r) begin
      we_r    <= we_nxt;
      color_r <= color_nxt;
    end
  end

  wbc_window u_window (
    .pix_x        (pix_x_r),
    .pix_y        (pix_y_r),
    .layer        (layer_r),
    .win0_rect    (win0_rect_r),
    .win1_rect    (win1_rect_r),
    .window_masks (window_masks_r),
    .res          (wres)
  );

  wbc_blend u_blend (
    .mode      (blend_mode_r),
    .coef_a    (coef_a_r),
    .coef_b    (coef_b_r),
    .coef_y    (coef_y_r),
    .fx        (wres.fx),
    .src_rgba  (src_r),
    .dst_color (dst_r),
    .color     (fx_color)
  );

  assign we_nxt    = wres.visible;
  assign color_nxt = wres.visible ? fx_color : dst_r;

  assign out_valid        = out_vld_r;
  assign out_write_enable = we_r;
  assign out_color        = color_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted pixel did not produce a result two cycles later");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_vld_r))
    else $error("result strobe without an accepted pixel");

  a_hidden_keeps_dst: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !we_nxt) |=> (out_valid && !out_write_enable &&
                               out_color == $past(dst_r)))
    else $error("hidden pixel did not return the destination word");

  a_bad_layer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && layer_r > 3'd4) |=> !out_write_enable)
    else $error("layer code above four was written");

endmodule

[verif/window_blend_compositor_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// window_blend_compositor_checker
// Watches the pixel, result and register channels of the compositor, keeps
// its own copy of the registers, predicts each output word (window mask
// resolve, layer enable, color effect) and compares it field by field.
// ---------------------------------------------------------------------------
module window_blend_compositor_checker import wbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [7:0]  in_pix_x,
  input  logic [7:0]  in_pix_y,
  input  logic [2:0]  in_layer,
  input  logic [31:0] in_src_rgba,
  input  logic [31:0] in_dst_color,
  input  logic        out_valid,
  input  logic        out_write_enable,
  input  logic [31:0] out_color,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int unsigned pending,
  output int unsigned fail_count
);

  typedef struct packed {
    logic        write_enable;
    logic [31:0] color;
  } pixel_word_t;

  pixel_word_t expected_pixels[$];
  int unsigned errs = 0;

  logic [31:0] rect0, rect1;
  logic [23:0] masks;
  blend_mode_t mode;
  logic [4:0]  wt_src, wt_dst, wt_lum;

  function automatic logic span_hit(input logic [7:0] lo, input logic [7:0] hi,
                                    input logic [7:0] c);
    if (lo <= hi) return (c >= lo) && (c < hi);
    return (c >= lo) || (c < hi);
  endfunction

  function automatic logic in_window(input logic [31:0] r, input logic [7:0] x,
                                     input logic [7:0] y);
    return span_hit(r[7:0], r[15:8], x) && span_hit(r[23:16], r[31:24], y);
  endfunction

  function automatic int unsigned limit_coef(input logic [4:0] c);
    return (c > CoefMax) ? CoefMax : c;
  endfunction

  function automatic pixel_word_t composite_pixel(input logic [7:0] x, input logic [7:0] y,
                                                  input logic [2:0] lyr,
                                                  input logic [31:0] src,
                                                  input logic [31:0] dst);
    pixel_word_t res;
    logic [7:0] m;
    int unsigned s, d, v, a, b, k, sh;
    if (in_window(rect0, x, y)) m = masks[7:0];
    else if (in_window(rect1, x, y)) m = masks[15:8];
    else m = masks[23:16];
    a = limit_coef(wt_src);
    b = limit_coef(wt_dst);
    k = limit_coef(wt_lum);
    res.write_enable = (lyr <= 3'd4) && m[lyr];
    if (!res.write_enable) begin
      res.color = dst;
    end else if (!m[5] || mode == BLEND_NONE) begin
      res.color = src;
    end else begin
      res.color = 32'h0000_00FF;
      for (sh = 8; sh <= 24; sh += 8) begin
        s = src[sh +: 8];
        d = dst[sh +: 8];
        case (mode)
          BLEND_ALPHA:    v = (s * a + d * b) / CoefMax;
          BLEND_BRIGHTEN: v = s + ((255 - s) * k) / CoefMax;
          default:        v = (s * (CoefMax - k)) / CoefMax;
        endcase
        if (v > 255) v = 255;
        res.color[sh +: 8] = v[7:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_word_t want;
    if (!rst_n) begin
      rect0 = '0;
      rect1 = '0;
      masks = 24'h3F0000;
      mode = BLEND_NONE;
      wt_src = '0;
      wt_dst = '0;
      wt_lum = '0;
      expected_pixels.delete();
    end else begin
      if (out_valid) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected output word: write_enable %0d color %08h",
                 out_write_enable, out_color);
          errs++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_write_enable !== want.write_enable) begin
            $error("out_write_enable: expected %0d, got %0d",
                   want.write_enable, out_write_enable);
            errs++;
          end
          if (out_color !== want.color) begin
            $error("out_color: expected %08h, got %08h", want.color, out_color);
            errs++;
          end
        end
      end
      if (start && !busy)
        expected_pixels.insert(expected_pixels.size(),
                               composite_pixel(in_pix_x, in_pix_y, in_layer,
                                               in_src_rgba, in_dst_color));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WIN0_RECT:    rect0 = cfg_data;
          REG_WIN1_RECT:    rect1 = cfg_data;
          REG_WINDOW_MASKS: masks = cfg_data[23:0];
          REG_BLEND_MODE:   mode = blend_mode_t'(cfg_data[1:0]);
          REG_COEF_A:       wt_src = cfg_data[4:0];
          REG_COEF_B:       wt_dst = cfg_data[4:0];
          REG_COEF_Y:       wt_lum = cfg_data[4:0];
          default: ;
        endcase
      end
    end
    pending <= expected_pixels.size();
    fail_count <= errs;
  end

endmodule

[verif/window_blend_compositor_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// window_blend_compositor_tb
// Drives pixels and register writes into the compositor: a short directed
// pass over windows, wrap, layers and effects, then randomized register
// settings with pixels biased toward window edges and random idle gaps.
// ---------------------------------------------------------------------------
module window_blend_compositor_tb;
  import wbc_pkg::*;

  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned RandPhases = 13;
  localparam int unsigned PhaseWords = 125;
  localparam logic [2:0]  UnusedReg  = 3'd7;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  in_pix_x = '0;
  logic [7:0]  in_pix_y = '0;
  logic [2:0]  in_layer = '0;
  logic [31:0] in_src_rgba = '0;
  logic [31:0] in_dst_color = '0;
  logic        out_valid;
  logic        out_write_enable;
  logic [31:0] out_color;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int unsigned pending, fail_count;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 27;
  logic [31:0] cur_rect0 = '0, cur_rect1 = '0;

  window_blend_compositor dut (.*);

  window_blend_compositor_checker pixel_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("window_blend_compositor regression: fail");
    $finish;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [31:0] r0, input logic [31:0] r1,
                          input logic [23:0] m, input blend_mode_t md,
                          input logic [4:0] a, input logic [4:0] b, input logic [4:0] y);
    cur_rect0 = r0;
    cur_rect1 = r1;
    write_reg(REG_WIN0_RECT, r0);
    write_reg(REG_WIN1_RECT, r1);
    write_reg(REG_WINDOW_MASKS, {8'($urandom()), m});
    write_reg(REG_BLEND_MODE, {30'($urandom()), md});
    write_reg(REG_COEF_A, {27'($urandom()), a});
    write_reg(REG_COEF_B, {27'($urandom()), b});
    write_reg(REG_COEF_Y, {27'($urandom()), y});
  endtask

  task automatic send_pixel(input logic [7:0] x, input logic [7:0] y, input logic [2:0] lyr,
                            input logic [31:0] src, input logic [31:0] dst);
    while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      in_src_rgba <= $urandom();
      @(posedge clk);
    end
    start        <= 1'b1;
    in_pix_x     <= x;
    in_pix_y     <= y;
    in_layer     <= lyr;
    in_src_rgba  <= src;
    in_dst_color <= dst;
    do @(posedge clk); while (busy);
  endtask

  // drain all outstanding words, then let the pipeline idle for the tail
  task automatic settle(input int unsigned tail);
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (tail) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_rect();
    case ($urandom_range(5, 0))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [4:0] pick_coef();
    case ($urandom_range(4, 0))
      0: return 5'd0;
      1: return 5'd16;
      2: return 5'd31;
      default: return 5'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] pick_color();
    case ($urandom_range(6, 0))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // coordinate on or just below a window bound; axis 0 is x, 1 is y
  function automatic logic [7:0] near_edge(input int unsigned axis);
    logic [31:0] r;
    logic [7:0] c;
    r = $urandom_range(1, 0) ? cur_rect0 : cur_rect1;
    c = r[16 * axis + 8 * $urandom_range(1, 0) +: 8];
    if ($urandom_range(1, 0)) c = c - 8'd1;
    return c;
  endfunction

  initial begin
    logic [7:0] x, y;
    logic [23:0] m;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: empty windows, outside mask all layers, no effect
    send_pixel(8'd0, 8'd0, 3'd0, 32'hFFFF_FFFF, 32'h0000_0000);
    send_pixel(8'd255, 8'd191, 3'd4, 32'h0000_0000, 32'hFFFF_FFFF);
    send_pixel(8'd128, 8'd64, 3'd1, 32'h1234_5678, 32'h9ABC_DEF0);
    send_pixel(8'd127, 8'd127, 3'd2, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_pixel(8'd1, 8'd190, 3'd3, 32'h8000_0001, 32'h7FFF_FFFE);
    send_pixel(8'd64, 8'd32, 3'd5, 32'hDEAD_BEEF, 32'h0BAD_F00D);
    send_pixel(8'd200, 8'd100, 3'd6, 32'hFFFF_FFFF, 32'h1111_1111);
    send_pixel(8'd255, 8'd0, 3'd7, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
    settle(3);
    write_reg(UnusedReg, $urandom());

    // window 0 plain, window 1 wrapping on both axes, alpha blend
    set_regs({8'd15, 8'd5, 8'd20, 8'd10}, {8'd30, 8'd150, 8'd50, 8'd200},
             {8'h3F, 8'h1E, 8'h21}, BLEND_ALPHA, 5'd31, 5'd8, 5'd0);
    send_pixel(8'd10, 8'd5, 3'd0, 32'hFF80_4010, 32'h1020_40FF);
    send_pixel(8'd19, 8'd14, 3'd1, 32'hFFFF_FFFF, 32'h0102_0304);
    send_pixel(8'd20, 8'd5, 3'd0, 32'h8888_8888, 32'h4444_4444);
    send_pixel(8'd220, 8'd160, 3'd4, 32'hCAFE_0042, 32'h0000_0000);
    send_pixel(8'd100, 8'd100, 3'd3, 32'hFFFF_FF00, 32'hFFFF_FFFF);
    send_pixel(8'd255, 8'd0, 3'd2, 32'h1357_9BDF, 32'h2468_ACE0);
    settle(3);

    set_regs('0, '0, 24'hFFFFFF, BLEND_BRIGHTEN, 5'd0, 5'd0, 5'd16);
    send_pixel(8'd0, 8'd0, 3'd0, 32'h0080_FF01, 32'hFFFF_FFFF);
    send_pixel(8'd77, 8'd33, 3'd4, 32'h1020_3040, 32'h0);
    settle(3);
    set_regs('0, '0, 24'hFFFFFF, BLEND_DARKEN, 5'd0, 5'd0, 5'd31);
    send_pixel(8'd5, 8'd6, 3'd2, 32'hFFFF_FFFF, 32'h0);
    send_pixel(8'd250, 8'd191, 3'd3, 32'h1234_5600, 32'hFFFF_FFFF);
    settle(3);
    set_regs('0, '0, 24'h3F0000, BLEND_ALPHA, 5'd16, 5'd16, 5'd7);
    send_pixel(8'd9, 8'd9, 3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(8'd90, 8'd90, 3'd0, 32'h7F80_0100, 32'h8080_FF55);
    settle(3);

    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      case ($urandom_range(3, 0))
        0: m = '0;
        1: m = '1;
        default: m = $urandom();
      endcase
      set_regs(pick_rect(), pick_rect(), m, blend_mode_t'(ph % 4),
               pick_coef(), pick_coef(), pick_coef());
      idle_pct = (ph == 6) ? 0 : 27;
      for (int unsigned i = 0; i < PhaseWords; i++) begin
        x = ($urandom_range(9, 0) < 3) ? near_edge(0) : 8'($urandom());
        y = ($urandom_range(9, 0) < 3) ? near_edge(1) : 8'($urandom_range(191, 0));
        if (y > 8'd191) y = 8'($urandom_range(191, 0));
        send_pixel(x, y,
                   ($urandom_range(99, 0) < 85) ? 3'($urandom_range(4, 0))
                                                : 3'($urandom_range(7, 5)),
                   pick_color(), pick_color());
      end
      settle(3);
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("window_blend_compositor regression: pass");
    end else begin
      $display("window_blend_compositor regression: fail");
    end
    $finish;
  end

endmodule
